### design/mi3_pkg.sv
// Package: widths, pipeline depth and stage types for the 3x3 inverse block.
package mi3_pkg;

    // Element and result formats
    localparam int ELEM_W = 16;
    localparam int ELEM_F = 12;
    localparam int OUT_W  = 32;
    localparam int OUT_F  = 16;

    // Exact intermediate widths
    localparam int PROD_W = 2 * ELEM_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int MAG_W  = COF_W - 1;
    localparam int DP_W   = COF_W + ELEM_W;
    localparam int DET_W  = 3 * ELEM_W + 2;
    localparam int DEN_W  = DET_W - 1;

    // Division layout: quotient bits kept, numerator scale and width
    localparam int Q_W    = OUT_W + 1;
    localparam int NUM_SH = ELEM_F + OUT_F;
    localparam int N_W    = MAG_W + NUM_SH + 1;
    localparam int HI_W   = N_W - Q_W;

    // Determinant conversion shift
    localparam int DET_SH = 3 * ELEM_F - OUT_F;
    localparam int DETR_W = DEN_W - DET_SH + 1;

    localparam int NUM_ENT  = 9;
    localparam int FRONT_STAGES = 5;
    localparam int DIV_STAGES   = Q_W;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   nq;
        logic             neg;
        logic             sat;
    } lane_t;

    typedef struct packed {
        logic [DEN_W-1:0]         den;
        lane_t [NUM_ENT-1:0]      lane;
        logic [OUT_W-1:0]         det_out;
        logic                     singular;
    } stage_t;

endpackage

### design/matrix3_inverse_determinant_top.sv
// Top level: 3x3 adjugate inverse with determinant, fully pipelined.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_stall | col0_x .. col2_z, signed Q3.12
//  output  | out_valid/out_stall | inv_r0_x .. inv_r2_z, determinant, singular
//
// One matrix per cycle while the output is not stalled. The pipeline has five
// front stages (products, cofactors, triple product, sum, divider setup), 33
// division steps and one output register. Reset clears only the valid bits. A stalled output freezes
// the whole pipeline; in_stall is high exactly while a result waits stalled.
module matrix3_inverse_determinant_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col0_x,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col0_y,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col0_z,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col1_x,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col1_y,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col1_z,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col2_x,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col2_y,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col2_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mi3_pkg::OUT_W-1:0]    inv_r0_x,
    output logic signed [mi3_pkg::OUT_W-1:0]    inv_r0_y,
    output logic signed [mi3_pkg::OUT_W-1:0]    inv_r0_z,
    output logic signed [mi3_pkg::OUT_W-1:0]    inv_r1_x,
    output logic signed [mi3_pkg::OUT_W-1:0]    inv_r1_y,
    output logic signed [mi3_pkg::OUT_W-1:0]    inv_r1_z,
    output logic signed [mi3_pkg::OUT_W-1:0]    inv_r2_x,
    output logic signed [mi3_pkg::OUT_W-1:0]    inv_r2_y,
    output logic signed [mi3_pkg::OUT_W-1:0]    inv_r2_z,
    output logic signed [mi3_pkg::OUT_W-1:0]    determinant,
    output logic                                singular
);

    logic                en;
    logic                dv [mi3_pkg::DIV_STAGES+1];
    mi3_pkg::stage_t     ds [mi3_pkg::DIV_STAGES+1];
    logic                out_valid_reg;
    logic [mi3_pkg::OUT_W-1:0] inv_reg  [mi3_pkg::NUM_ENT];
    logic [mi3_pkg::OUT_W-1:0] inv_next [mi3_pkg::NUM_ENT];
    logic [mi3_pkg::OUT_W-1:0] det_reg;
    logic                      sing_reg;

    // Hold everything while a result waits stalled
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    mi3_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_take  (in_valid),
        .col0_x   (col0_x),
        .col0_y   (col0_y),
        .col0_z   (col0_z),
        .col1_x   (col1_x),
        .col1_y   (col1_y),
        .col1_z   (col1_z),
        .col2_x   (col2_x),
        .col2_y   (col2_y),
        .col2_z   (col2_z),
        .st_valid (dv[0]),
        .st       (ds[0])
    );

    for (genvar g = 0; g < mi3_pkg::DIV_STAGES; g++)
    begin : g_div
        mi3_div_stage u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .in_v   (dv[g]),
            .in_st  (ds[g]),
            .out_v  (dv[g+1]),
            .out_st (ds[g+1])
        );
    end

    // Saturate quotients, zero them for a singular matrix
    always_comb
    begin
        logic [mi3_pkg::Q_W-1:0] q;
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++)
        begin
            q = ds[mi3_pkg::DIV_STAGES].lane[i].nq;
            if (ds[mi3_pkg::DIV_STAGES].singular)
            begin
                inv_next[i] = '0;
            end
            else if (ds[mi3_pkg::DIV_STAGES].lane[i].neg)
            begin
                if (ds[mi3_pkg::DIV_STAGES].lane[i].sat || q[mi3_pkg::Q_W-1:mi3_pkg::OUT_W-1] > 2'd1
                    || (q[mi3_pkg::OUT_W-1] && q[mi3_pkg::OUT_W-2:0] != '0))
                begin
                    inv_next[i] = {1'b1, {(mi3_pkg::OUT_W-1){1'b0}}};
                end
                else
                begin
                    inv_next[i] = mi3_pkg::OUT_W'(-q);
                end
            end
            else
            begin
                if (ds[mi3_pkg::DIV_STAGES].lane[i].sat || q[mi3_pkg::Q_W-1:mi3_pkg::OUT_W-1] != '0)
                begin
                    inv_next[i] = {1'b0, {(mi3_pkg::OUT_W-1){1'b1}}};
                end
                else
                begin
                    inv_next[i] = q[mi3_pkg::OUT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv[mi3_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg  <= inv_next;
            det_reg  <= ds[mi3_pkg::DIV_STAGES].singular ? '0
                                                         : ds[mi3_pkg::DIV_STAGES].det_out;
            sing_reg <= ds[mi3_pkg::DIV_STAGES].singular;
        end
    end

    assign out_valid   = out_valid_reg;
    assign inv_r0_x    = inv_reg[0];
    assign inv_r0_y    = inv_reg[1];
    assign inv_r0_z    = inv_reg[2];
    assign inv_r1_x    = inv_reg[3];
    assign inv_r1_y    = inv_reg[4];
    assign inv_r1_z    = inv_reg[5];
    assign inv_r2_x    = inv_reg[6];
    assign inv_r2_y    = inv_reg[7];
    assign inv_r2_z    = inv_reg[8];
    assign determinant = det_reg;
    assign singular    = sing_reg;

endmodule

### design/mi3_front.sv
// Front pipeline: cross products, cofactors, determinant and divider setup.
module mi3_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_take,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col0_x,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col0_y,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col0_z,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col1_x,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col1_y,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col1_z,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col2_x,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col2_y,
    input  logic signed [mi3_pkg::ELEM_W-1:0]   col2_z,
    output logic                                st_valid,
    output mi3_pkg::stage_t                     st
);

    logic signed [mi3_pkg::ELEM_W-1:0] vin [3][3];

    logic signed [mi3_pkg::PROD_W-1:0] p1_reg [3][3];
    logic signed [mi3_pkg::PROD_W-1:0] p2_reg [3][3];
    logic signed [mi3_pkg::ELEM_W-1:0] c1_reg [3];
    logic signed [mi3_pkg::COF_W-1:0]  cof2_reg [3][3];
    logic signed [mi3_pkg::ELEM_W-1:0] c2_reg [3];
    logic signed [mi3_pkg::COF_W-1:0]  cof3_reg [3][3];
    logic signed [mi3_pkg::DP_W-1:0]   dp3_reg [3];
    logic signed [mi3_pkg::COF_W-1:0]  cof4_reg [3][3];
    logic signed [mi3_pkg::DET_W-1:0]  det4_reg;
    mi3_pkg::stage_t                   st_next;
    mi3_pkg::stage_t                   st_reg;
    logic [mi3_pkg::FRONT_STAGES-1:0]  v_reg;

    logic [mi3_pkg::DEN_W-1:0]   den;
    logic [mi3_pkg::DET_W-1:0]   det_u;
    logic [mi3_pkg::DEN_W:0]     det_rnd;
    logic [mi3_pkg::DETR_W-1:0]  det_r;
    logic                        det_neg;

    // Gather the columns
    always_comb
    begin
        vin[0][0] = col0_x; vin[0][1] = col0_y; vin[0][2] = col0_z;
        vin[1][0] = col1_x; vin[1][1] = col1_y; vin[1][2] = col1_z;
        vin[2][0] = col2_x; vin[2][1] = col2_y; vin[2][2] = col2_z;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[mi3_pkg::FRONT_STAGES-2:0], in_take};
        end
    end

    // Stages one to four: products, cofactors, triple product terms, determinant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p1_reg[k][j] <= vin[(k+1)%3][(j+1)%3] * vin[(k+2)%3][(j+2)%3];
                    p2_reg[k][j] <= vin[(k+1)%3][(j+2)%3] * vin[(k+2)%3][(j+1)%3];
                    cof2_reg[k][j] <= mi3_pkg::COF_W'(p1_reg[k][j])
                                    - mi3_pkg::COF_W'(p2_reg[k][j]);
                    cof3_reg[k][j] <= cof2_reg[k][j];
                    cof4_reg[k][j] <= cof3_reg[k][j];
                end
                c1_reg[k]  <= vin[2][k];
                c2_reg[k]  <= c1_reg[k];
                dp3_reg[k] <= cof2_reg[2][k] * c2_reg[k];
            end
            det4_reg <= mi3_pkg::DET_W'(dp3_reg[0]) + mi3_pkg::DET_W'(dp3_reg[1])
                      + mi3_pkg::DET_W'(dp3_reg[2]);
            st_reg <= st_next;
        end
    end

    // Stage five: magnitudes, overflow precheck, determinant rounding
    always_comb
    begin
        logic [mi3_pkg::COF_W-1:0] cu;
        logic [mi3_pkg::MAG_W-1:0] cm;
        logic [mi3_pkg::N_W-1:0]   num;
        logic [mi3_pkg::HI_W-1:0]  hi;
        det_u   = det4_reg;
        den     = det_u[mi3_pkg::DET_W-1] ? mi3_pkg::DEN_W'(-det_u)
                                          : det_u[mi3_pkg::DEN_W-1:0];
        det_rnd = {1'b0, den} + (mi3_pkg::DEN_W+1)'(1) * (1 << (mi3_pkg::DET_SH - 1));
        det_r   = det_rnd[mi3_pkg::DEN_W:mi3_pkg::DET_SH];
        det_neg = det_u[mi3_pkg::DET_W-1] && (det_r != '0);
        st_next.den      = den;
        st_next.singular = (det_u == '0);
        st_next.det_out  = det_neg ? -mi3_pkg::OUT_W'(det_r)
                                   : mi3_pkg::OUT_W'(det_r);
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cu  = cof4_reg[k][j];
                cm  = cu[mi3_pkg::COF_W-1] ? mi3_pkg::MAG_W'(-cu) : cu[mi3_pkg::MAG_W-1:0];
                num = {1'b0, cm, {mi3_pkg::NUM_SH{1'b0}}} + mi3_pkg::N_W'(den >> 1);
                hi  = num[mi3_pkg::N_W-1:mi3_pkg::Q_W];
                st_next.lane[k*3+j].sat = (mi3_pkg::DEN_W'(hi) >= den);
                st_next.lane[k*3+j].rem = (mi3_pkg::DEN_W'(hi) >= den) ? '0
                                                                      : mi3_pkg::DEN_W'(hi);
                st_next.lane[k*3+j].nq  = num[mi3_pkg::Q_W-1:0];
                st_next.lane[k*3+j].neg = cu[mi3_pkg::COF_W-1] ^ det_u[mi3_pkg::DET_W-1];
            end
        end
    end

    assign st_valid = v_reg[mi3_pkg::FRONT_STAGES-1];
    assign st       = st_reg;

endmodule

### design/mi3_div_stage.sv
// One restoring division step for all nine entries, registered.
module mi3_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_v,
    input  mi3_pkg::stage_t in_st,
    output logic            out_v,
    output mi3_pkg::stage_t out_st
);

    mi3_pkg::stage_t st_next;
    mi3_pkg::stage_t st_reg;
    logic            v_reg;

    // Shift in one numerator bit, subtract where the divisor fits
    always_comb
    begin
        logic [mi3_pkg::DEN_W:0] rs;
        logic [mi3_pkg::DEN_W:0] df;
        st_next = in_st;
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++)
        begin
            rs = {in_st.lane[i].rem, in_st.lane[i].nq[mi3_pkg::Q_W-1]};
            df = rs - {1'b0, in_st.den};
            if (!df[mi3_pkg::DEN_W])
            begin
                st_next.lane[i].rem = df[mi3_pkg::DEN_W-1:0];
            end
            else
            begin
                st_next.lane[i].rem = rs[mi3_pkg::DEN_W-1:0];
            end
            st_next.lane[i].nq = {in_st.lane[i].nq[mi3_pkg::Q_W-2:0], ~df[mi3_pkg::DEN_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign out_v  = v_reg;
    assign out_st = st_reg;

endmodule

### design/mi3_checker.sv
// Port checker for the 3x3 inverse block, bound to the top level.
module mi3_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [mi3_pkg::OUT_W-1:0]        inv_r0_x,
    input logic [mi3_pkg::OUT_W-1:0]        inv_r2_z,
    input logic [mi3_pkg::OUT_W-1:0]        determinant,
    input logic                             singular
);

    // Input stalls only while a finished result waits
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the output stall");

    // A singular result carries zero outputs
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (determinant == '0 && inv_r0_x == '0 && inv_r2_z == '0))
        else $error("singular item with nonzero outputs");

    // No item shows right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // Stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(determinant) && $stable(singular)))
        else $error("stalled item changed");

endmodule

bind matrix3_inverse_determinant_top mi3_checker u_mi3_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .inv_r0_x    (inv_r0_x),
    .inv_r2_z    (inv_r2_z),
    .determinant (determinant),
    .singular    (singular)
);

### test/mi3_checker.sv
// Checker: predicts the 3x3 inverse and determinant and compares every result item.
`timescale 1ns / 1ps

module mi3_scoreboard (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic signed [mi3_pkg::ELEM_W-1:0] col0_x,
    input  logic signed [mi3_pkg::ELEM_W-1:0] col0_y,
    input  logic signed [mi3_pkg::ELEM_W-1:0] col0_z,
    input  logic signed [mi3_pkg::ELEM_W-1:0] col1_x,
    input  logic signed [mi3_pkg::ELEM_W-1:0] col1_y,
    input  logic signed [mi3_pkg::ELEM_W-1:0] col1_z,
    input  logic signed [mi3_pkg::ELEM_W-1:0] col2_x,
    input  logic signed [mi3_pkg::ELEM_W-1:0] col2_y,
    input  logic signed [mi3_pkg::ELEM_W-1:0] col2_z,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv_r0_x,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv_r0_y,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv_r0_z,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv_r1_x,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv_r1_y,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv_r1_z,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv_r2_x,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv_r2_y,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv_r2_z,
    input  logic signed [mi3_pkg::OUT_W-1:0]  determinant,
    input  logic                              singular,
    output int                                mismatches,
    output int                                inverses_pending
);

    typedef struct packed {
        logic [mi3_pkg::NUM_ENT-1:0][mi3_pkg::OUT_W-1:0] inv;
        logic [mi3_pkg::OUT_W-1:0]                       det;
        logic                                            sing;
    } inverse_t;

    inverse_t expected_inverses[$];

    // Clamp a sign and magnitude to the signed output range
    function automatic logic [mi3_pkg::OUT_W-1:0] clamp_out(bit neg, longint unsigned mag);
        longint unsigned lim;
        lim = longint'(1) << (mi3_pkg::OUT_W - 1);
        if (neg)
        begin
            if (mag > lim)
                mag = lim;
            return mi3_pkg::OUT_W'(longint'(0) - longint'(mag));
        end
        if (mag > lim - 1)
            mag = lim - 1;
        return mi3_pkg::OUT_W'(mag);
    endfunction

    // Cofactor over determinant, rounded half away from zero
    function automatic logic [mi3_pkg::OUT_W-1:0] cofactor_quotient(longint cof, longint det);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        bit              neg;
        num = longint'(cof < 0 ? -cof : cof) << (mi3_pkg::ELEM_F + mi3_pkg::OUT_F);
        den = longint'(det < 0 ? -det : det);
        neg = (cof < 0) != (det < 0);
        q = (num + den / 2) / den;
        if (q == 0)
            neg = 0;
        return clamp_out(neg, q);
    endfunction

    function automatic inverse_t predict_inverse(logic [8:0][mi3_pkg::ELEM_W-1:0] m);
        longint   a[3];
        longint   b[3];
        longint   c[3];
        longint   cof[9];
        longint   det;
        longint unsigned dmag;
        longint unsigned r;
        inverse_t res;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'($signed(m[i]));
            b[i] = longint'($signed(m[3 + i]));
            c[i] = longint'($signed(m[6 + i]));
        end
        // Cofactor rows b x c, c x a, a x b
        cof[0] = b[1] * c[2] - b[2] * c[1];
        cof[1] = b[2] * c[0] - b[0] * c[2];
        cof[2] = b[0] * c[1] - b[1] * c[0];
        cof[3] = c[1] * a[2] - c[2] * a[1];
        cof[4] = c[2] * a[0] - c[0] * a[2];
        cof[5] = c[0] * a[1] - c[1] * a[0];
        cof[6] = a[1] * b[2] - a[2] * b[1];
        cof[7] = a[2] * b[0] - a[0] * b[2];
        cof[8] = a[0] * b[1] - a[1] * b[0];
        det = cof[6] * c[0] + cof[7] * c[1] + cof[8] * c[2];
        res = '0;
        if (det == 0)
        begin
            res.sing = 1'b1;
            return res;
        end
        for (int k = 0; k < mi3_pkg::NUM_ENT; k++)
            res.inv[k] = cofactor_quotient(cof[k], det);
        dmag = longint'(det < 0 ? -det : det);
        r = (dmag + (longint'(1) << (mi3_pkg::DET_SH - 1))) >> mi3_pkg::DET_SH;
        res.det = clamp_out(det < 0 && r != 0, r);
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [mi3_pkg::OUT_W-1:0] got,
                                   logic [mi3_pkg::OUT_W-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    initial
    begin
        mismatches = 0;
        inverses_pending = 0;
    end

    // Predict on each accepted item, compare on each accepted result
    always @(posedge clk)
    begin
        inverse_t want;
        inverse_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_inverses.push_back(predict_inverse({col2_z, col2_y, col2_x,
                    col1_z, col1_y, col1_x, col0_z, col0_y, col0_x}));
            if (out_valid && !out_stall)
            begin
                got.inv = {inv_r2_z, inv_r2_y, inv_r2_x, inv_r1_z, inv_r1_y, inv_r1_x,
                           inv_r0_z, inv_r0_y, inv_r0_x};
                got.det = determinant;
                got.sing = singular;
                if (expected_inverses.size() == 0)
                begin
                    report_mismatch("unexpected item determinant", got.det, '0);
                end
                else
                begin
                    want = expected_inverses.pop_front();
                    for (int k = 0; k < mi3_pkg::NUM_ENT; k++)
                        if (got.inv[k] !== want.inv[k])
                            report_mismatch($sformatf("inv_r%0d_%s", k / 3,
                                k % 3 == 0 ? "x" : (k % 3 == 1 ? "y" : "z")),
                                got.inv[k], want.inv[k]);
                    if (got.det !== want.det)
                        report_mismatch("determinant", got.det, want.det);
                    if (got.sing !== want.sing)
                        report_mismatch("singular", mi3_pkg::OUT_W'(got.sing),
                                        mi3_pkg::OUT_W'(want.sing));
                end
            end
            inverses_pending = expected_inverses.size();
        end
    end

endmodule

### test/tb_matrix3_inverse_determinant_top.sv
// Testbench top: drives matrices into the 3x3 inverse block and gives the verdict.
`timescale 1ns / 1ps

module tb_matrix3_inverse_determinant_top;

    localparam int ONE = 4096;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [mi3_pkg::ELEM_W-1:0] col0_x, col0_y, col0_z;
    logic signed [mi3_pkg::ELEM_W-1:0] col1_x, col1_y, col1_z;
    logic signed [mi3_pkg::ELEM_W-1:0] col2_x, col2_y, col2_z;
    logic out_valid;
    logic out_stall;
    logic signed [mi3_pkg::OUT_W-1:0] inv_r0_x, inv_r0_y, inv_r0_z;
    logic signed [mi3_pkg::OUT_W-1:0] inv_r1_x, inv_r1_y, inv_r1_z;
    logic signed [mi3_pkg::OUT_W-1:0] inv_r2_x, inv_r2_y, inv_r2_z;
    logic signed [mi3_pkg::OUT_W-1:0] determinant;
    logic singular;
    int mismatches;
    int inverses_pending;

    int tx_idle_pct;
    int rx_stall_pct;
    bit long_hold_req;
    int hold_left;
    int cycles;

    matrix3_inverse_determinant_top dut (.*);
    mi3_scoreboard checker_i (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Abort on a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stall, or a long hold-off on request
    initial
    begin
        out_stall = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Offer one matrix and hold it until accepted
    task automatic send_matrix(logic [8:0][mi3_pkg::ELEM_W-1:0] m);
        in_valid <= 1'b1;
        {col2_z, col2_y, col2_x, col1_z, col1_y, col1_x, col0_z, col0_y, col0_x} <= m;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_sender(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic gap_maybe();
        if ($urandom_range(99) < tx_idle_pct)
            idle_sender($urandom_range(1, 4));
    endtask

    function automatic logic [8:0][mi3_pkg::ELEM_W-1:0] diag(int d0, int d1, int d2);
        logic [8:0][mi3_pkg::ELEM_W-1:0] m;
        m = '0;
        m[0] = mi3_pkg::ELEM_W'(d0);
        m[4] = mi3_pkg::ELEM_W'(d1);
        m[8] = mi3_pkg::ELEM_W'(d2);
        return m;
    endfunction

    function automatic logic [mi3_pkg::ELEM_W-1:0] edge_value();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0001;
            default: return 16'h0000;
        endcase
    endfunction

    // Random matrix: mostly general, some singular, tiny or extreme
    function automatic logic [8:0][mi3_pkg::ELEM_W-1:0] random_matrix();
        logic [8:0][mi3_pkg::ELEM_W-1:0] m;
        int mode;
        mode = $urandom_range(9);
        for (int i = 0; i < 9; i++)
        begin
            case (mode)
                4, 5: m[i] = mi3_pkg::ELEM_W'($urandom_range(2 * ONE) - ONE);
                7: m[i] = mi3_pkg::ELEM_W'($urandom_range(16) - 8);
                8: m[i] = edge_value();
                default: m[i] = mi3_pkg::ELEM_W'($urandom);
            endcase
        end
        if (mode == 4)
        begin
            m[0] = m[0] + ONE;
            m[4] = m[4] + ONE;
            m[8] = m[8] + ONE;
        end
        // Repeat a column to force a singular matrix
        if (mode == 6)
            for (int i = 0; i < 3; i++)
                m[6 + i] = m[$urandom_range(1) * 3 + i];
        if (mode == 9)
            for (int i = 0; i < 3; i++)
                m[3 + i] = m[i];
        return m;
    endfunction

    initial
    begin
        logic [8:0][mi3_pkg::ELEM_W-1:0] m;
        in_valid = 0;
        {col2_z, col2_y, col2_x, col1_z, col1_y, col1_x, col0_z, col0_y, col0_x} = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        long_hold_req = 0;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed matrices
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(-ONE, ONE, ONE));
        send_matrix('0);
        send_matrix(diag(1, 1, 1));
        send_matrix(diag(1, ONE, ONE));
        send_matrix(diag(32767, 32767, 32767));
        send_matrix(diag(-32768, -32768, -32768));
        send_matrix(diag(-32768, 32767, -1));
        send_matrix(diag(ONE / 2, 2 * ONE, ONE));
        send_matrix({9{16'h7fff}});
        send_matrix({9{16'h8000}});
        send_matrix({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                     16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
        send_matrix({16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
                     16'h0000, 16'h0000, 16'h0000, 16'h7fff});
        m = diag(ONE, 2 * ONE, 3 * ONE);
        m[3] = 16'd1000;
        m[7] = -16'sd2000;
        send_matrix(m);
        m = diag(0, 0, 0);
        m[1] = ONE;
        m[5] = ONE;
        m[6] = ONE;
        send_matrix(m);
        m = diag(3, 5, 7);
        m[1] = -2;
        send_matrix(m);
        m = diag(1, 1, 0);
        send_matrix(m);

        // Fill the block while the receiver holds off
        long_hold_req = 1;
        repeat (60) send_matrix(random_matrix());

        // Drain completely before the random phases
        idle_sender(1);
        while (inverses_pending != 0)
            @(posedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            for (int n = 0; n < 110; n++)
            begin
                gap_maybe();
                send_matrix(random_matrix());
            end
        end

        // Wait out the tail of the pipeline
        idle_sender(1);
        while (inverses_pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
